[rtl/pfma_pkg.sv]
// Shared types and constants for the partial-fill moving-average filter.
package pfma_pkg;

    localparam int RPM_W          = 20;
    localparam int FILL_W         = 4;
    localparam int DEPTH_DEFAULT  = 8;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 24;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic out_load;
    } pfma_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic next_empty;
        logic div_last;
    } pfma_stat_t;

endpackage

[rtl/pfma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfma_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/pfma_dp.sv]
// Datapath: input capture, ring buffer, running total, serial divider, output register.
module pfma_dp #(
    parameter int FILTER_DEPTH = pfma_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pfma_pkg::pfma_cmd_t           cmd,
    output pfma_pkg::pfma_stat_t          stat,
    input  logic                          in_cmd,
    input  logic [pfma_pkg::RPM_W-1:0]    in_sample,
    input  logic [pfma_pkg::RPM_W-1:0]    in_live,
    output logic [pfma_pkg::RPM_W-1:0]    out_avg,
    output logic [pfma_pkg::FILL_W-1:0]   out_fill
);
    import pfma_pkg::*;

    localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
    localparam int SLOT_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int TOT_W  = RPM_W + CNT_W;
    localparam int DIVC_W = $clog2(TOT_W);

    logic              cmd_reg;
    logic [RPM_W-1:0]  sample_reg;
    logic [RPM_W-1:0]  live_reg;
    logic [SLOT_W-1:0] slot_reg,  slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [RPM_W-1:0]  old_sample;
    logic              full;

    logic [TOT_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvsr_reg;
    logic [DIVC_W-1:0] divc_reg;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;

    logic [RPM_W-1:0]  avg_reg;
    logic [FILL_W-1:0] fill_reg;

    // Ring buffer of held samples
    pfma_ram #(
        .WIDTH (RPM_W),
        .DEPTH (FILTER_DEPTH),
        .AW    (SLOT_W)
    ) u_ring (
        .clk     (aclk),
        .wr_en   (cmd.update && (cmd_reg == CMD_PUSH)),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (cmd.capture),
        .rd_addr (slot_reg),
        .rd_data (old_sample)
    );

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= in_cmd;
            sample_reg <= in_sample;
            live_reg   <= in_live;
        end
    end

    assign full = (count_reg == CNT_W'(FILTER_DEPTH));

    // Filter state update: clear, or push with drop of the overwritten sample
    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (cmd_reg == CMD_CLEAR) begin
            slot_next  = '0;
            count_next = '0;
            total_next = '0;
        end else begin
            if (full) begin
                total_next = total_reg - TOT_W'(old_sample) + TOT_W'(sample_reg);
            end else begin
                total_next = total_reg + TOT_W'(sample_reg);
                count_next = count_reg + CNT_W'(1);
            end
            if (slot_reg == SLOT_W'(FILTER_DEPTH - 1)) begin
                slot_next = '0;
            end else begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end else if (cmd.update) begin
            slot_reg  <= slot_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Restoring divider, one quotient bit per step
    assign rem_sh = {rem_reg, quo_reg[TOT_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dvsr_reg});

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            quo_reg  <= total_next;
            rem_reg  <= '0;
            dvsr_reg <= count_next;
            divc_reg <= DIVC_W'(TOT_W - 1);
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[TOT_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? CNT_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[CNT_W-1:0];
            divc_reg <= divc_reg - DIVC_W'(1);
        end
    end

    assign stat.div_last   = (divc_reg == '0);
    assign stat.next_empty = (count_next == '0);

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            avg_reg  <= (count_reg == '0) ? live_reg : quo_reg[RPM_W-1:0];
            fill_reg <= FILL_W'(count_reg);
        end
    end

    assign out_avg  = avg_reg;
    assign out_fill = fill_reg;

    // A clear empties the filter; a push always leaves a sample held
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && (cmd_reg == CMD_CLEAR) |=> (count_reg == '0) && (total_reg == '0))
        else $error("clear did not empty the filter");

    a_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && (cmd_reg == CMD_PUSH) |=> (count_reg != '0))
        else $error("push left the filter empty");

endmodule

[rtl/pfma_ctrl.sv]
// Controller: sequences capture, update, division and result handoff per item.
module pfma_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  pfma_pkg::pfma_stat_t  stat,
    output pfma_pkg::pfma_cmd_t   cmd
);
    import pfma_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = stat.next_empty ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // An accepted item goes straight to the update step
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> (state_reg == ST_UPD))
        else $error("accepted item did not enter update");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("output register overwritten while stalled");

endmodule

[rtl/partial_fill_moving_average_top.sv]
// Top level of the partial-fill moving-average speed filter.
//
// Input channel s_*: one item per command. s_tuser carries the command
// (push a sample or clear the filter); s_tdata carries the sample and the
// live speed. Result channel m_*: exactly one result per item, holding the
// truncated mean of the held samples (or the live speed while none is held)
// and the fill count.
// Timing: an item is taken only while the block is idle. Every push runs
// a restoring divider, one quotient bit per cycle over the running-total
// width (20 + clog2(FILTER_DEPTH+1) bits, 24 at depth 8), between the
// update step and the output load. A clear skips the divider.
// The ring buffer is a RAM with a registered read, read in the accept cycle.
// Reset (aresetn low, synchronous) empties the filter and drops any pending
// result; ring contents are not cleared, since an old sample is only used
// once the ring has filled again. A stalled receiver holds the result in
// the output register; one further item is taken and worked on meanwhile,
// and it waits in its last step until the register frees.
module partial_fill_moving_average_top #(
    parameter int FILTER_DEPTH = pfma_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pfma_pkg::S_TDATA_W-1:0]   s_tdata,   // [19:0] sample_rpm, [39:20] live_rpm
    input  logic                             s_tuser,   // [0] cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pfma_pkg::M_TDATA_W-1:0]   m_tdata    // [19:0] average_rpm, [23:20] fill_count
);
    import pfma_pkg::*;

    pfma_cmd_t         cmd;
    pfma_stat_t        stat;
    logic [RPM_W-1:0]  avg;
    logic [FILL_W-1:0] fill;

    pfma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfma_dp #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_cmd    (s_tuser),
        .in_sample (s_tdata[RPM_W-1:0]),
        .in_live   (s_tdata[2*RPM_W-1:RPM_W]),
        .out_avg   (avg),
        .out_fill  (fill)
    );

    // Pack the result item
    assign m_tdata = {fill, avg};

endmodule

[tb/sv/partial_fill_moving_average_top_test.sv]
// Self-checking stream testbench for the partial-fill moving-average speed filter.
module partial_fill_moving_average_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pfma_pkg::*;

    localparam int FILTER_DEPTH = DEPTH_DEFAULT;
    localparam int COUNT_W      = $clog2(FILTER_DEPTH + 1);
    localparam int SLOT_W       = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int TOTAL_W      = RPM_W + $clog2(FILTER_DEPTH + 1);
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [RPM_W-1:0] RPM_MAX = '1;

    typedef struct packed {
        logic [RPM_W-1:0]  average_rpm;
        logic [FILL_W-1:0] fill_count;
    } filter_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = CMD_PUSH;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Own copy of the filter state
    logic [RPM_W-1:0]   ring_copy [FILTER_DEPTH];
    logic [SLOT_W-1:0]  next_slot;
    logic [COUNT_W-1:0] samples_held;
    logic [TOTAL_W-1:0] sample_sum;

    filter_result_t average_q [$];
    int             fail_count = 0;
    bit             idle_on    = 1'b1;
    int unsigned    hold_seq   = 0;
    int unsigned    hold_seen  = 0;
    int unsigned    rx_wait    = 0;
    int unsigned    quiet_cycles = 0;

    partial_fill_moving_average_top #(
        .FILTER_DEPTH(FILTER_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Empty the filter copy
    function automatic void empty_filter_copy();
        ring_copy    = '{default: '0};
        next_slot    = '0;
        samples_held = '0;
        sample_sum   = '0;
    endfunction

    // Apply one item to the filter copy and return the result it causes
    function automatic filter_result_t advance_filter(logic cmd, logic [RPM_W-1:0] sample,
                                                      logic [RPM_W-1:0] live);
        filter_result_t     res;
        logic [TOTAL_W-1:0] quotient;
        if (cmd == CMD_CLEAR) begin
            empty_filter_copy();
        end else begin
            // Full ring: drop the sample being overwritten
            if (samples_held >= COUNT_W'(FILTER_DEPTH))
                sample_sum = sample_sum - TOTAL_W'(ring_copy[next_slot]);
            else
                samples_held = samples_held + 1'b1;
            ring_copy[next_slot] = sample;
            sample_sum = sample_sum + TOTAL_W'(sample);
            next_slot = (next_slot == SLOT_W'(FILTER_DEPTH - 1)) ? '0 : next_slot + 1'b1;
        end
        if (samples_held == '0) begin
            res.average_rpm = live;
        end else begin
            quotient = sample_sum / TOTAL_W'(samples_held);
            res.average_rpm = quotient[RPM_W-1:0];
        end
        res.fill_count = FILL_W'(samples_held);
        return res;
    endfunction

    // Predict on every accepted item, check every accepted result
    always @(posedge aclk) begin : result_check
        filter_result_t want;
        if (!aresetn) begin
            empty_filter_copy();
        end else begin
            if (s_tvalid && s_tready)
                average_q.push_back(advance_filter(s_tuser, s_tdata[RPM_W-1:0],
                                                   s_tdata[2*RPM_W-1:RPM_W]));
            if (m_tvalid && m_tready) begin
                if (average_q.size() == 0) begin
                    $error("unexpected result: average_rpm %0d fill_count %0d",
                           m_tdata[RPM_W-1:0], m_tdata[RPM_W +: FILL_W]);
                    fail_count++;
                end else begin
                    want = average_q.pop_front();
                    if (m_tdata[RPM_W-1:0] !== want.average_rpm) begin
                        $error("average_rpm: expected %0d, actual %0d",
                               want.average_rpm, m_tdata[RPM_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[RPM_W +: FILL_W] !== want.fill_count) begin
                        $error("fill_count: expected %0d, actual %0d",
                               want.fill_count, m_tdata[RPM_W +: FILL_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            m_tready  <= 1'b0;
            rx_wait   <= HOLD_CYCLES - 1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_wait  <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offer one item until taken, then maybe idle for a burst
    task automatic send_item(input logic cmd, input logic [RPM_W-1:0] sample,
                             input logic [RPM_W-1:0] live);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {live, sample};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Hold the sender until every expected result has come
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (average_q.size() != 0) @(posedge aclk);
    endtask

    // Speed sample biased toward small values and the top of the range
    function automatic logic [RPM_W-1:0] pick_rpm();
        case ($urandom_range(0, 4))
            0:       return RPM_W'($urandom_range(0, 15));
            1:       return RPM_MAX;
            2:       return RPM_MAX - RPM_W'($urandom_range(0, 255));
            default: return RPM_W'($urandom());
        endcase
    endfunction

    // Extremes, clears, an empty filter, fill-up and full-ring overwrite
    task automatic test_directed_extremes();
        send_item(CMD_CLEAR, RPM_MAX, RPM_MAX);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_PUSH, '0, RPM_MAX);
        for (int i = 0; i < FILTER_DEPTH; i++) send_item(CMD_PUSH, RPM_MAX, '0);
        for (int i = 0; i < FILTER_DEPTH; i++) send_item(CMD_PUSH, '0, RPM_MAX);
        send_item(CMD_PUSH, 20'd1, 20'h55555);
        send_item(CMD_CLEAR, 20'hAAAAA, 20'h55555);
        send_item(CMD_PUSH, RPM_MAX, '0);
        send_item(CMD_CLEAR, 20'h55555, 20'hAAAAA);
        send_item(CMD_PUSH, 20'hAAAAA, 20'h55555);
    endtask

    // Hold off the receiver while items keep coming, then drain
    task automatic test_output_holdoff();
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 12; i++) send_item(CMD_PUSH, pick_rpm(), RPM_W'($urandom()));
        wait_for_results();
        for (int i = 0; i < 4; i++) send_item(CMD_PUSH, pick_rpm(), RPM_W'($urandom()));
        wait_for_results();
    endtask

    // Mostly pushes with occasional clears, under random idling
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_PUSH,
                      pick_rpm(), RPM_W'($urandom()));
    endtask

    // Same traffic with both sides always ready
    task automatic test_full_rate(input int count);
        idle_on = 1'b0;
        test_random_mix(count);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_output_holdoff();
        test_random_mix(1150);
        test_full_rate(300);
        wait_for_results();
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/pfma_pkg.sv
rtl/pfma_ram.sv
rtl/pfma_dp.sv
rtl/pfma_ctrl.sv
rtl/partial_fill_moving_average_top.sv
tb/sv/partial_fill_moving_average_top_test.sv
